[rtl/double_ended_queue_macros.svh]
// Assertion macros for the double-ended queue.
// Included by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Check a property while out of reset.
`define DQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
// No dependencies; imported by dq_cell, dq_chain and double_ended_queue.
package dq_pkg;

    localparam int VALUE_W      = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What each cell of a chain does at a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_SHR  = 2'd1,
        CELL_SHL  = 2'd2,
        CELL_LOAD = 2'd3
    } t_cell_op;

endpackage

[rtl/dq_cell.sv]
// One storage cell of a queue chain: holds a word, takes it from either neighbor or a load.
// Depends on dq_pkg.
module dq_cell
    import dq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_op                  i_op,
    input  logic signed [VALUE_W-1:0] i_left,
    input  logic signed [VALUE_W-1:0] i_right,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic signed [VALUE_W-1:0] o_data
);

    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_SHR:  n_data = i_left;
            CELL_SHL:  n_data = i_right;
            CELL_LOAD: n_data = i_value;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/dq_chain.sv]
// Row of dq_cell instances holding the queue packed from cell 0 onward.
// Depends on dq_pkg and dq_cell.
module dq_chain
    import dq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic                      i_clk,
    input  t_cell_op                  i_op,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic signed [VALUE_W-1:0] o_head
);

    logic signed [VALUE_W-1:0] w_data [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_op                  w_op;
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;

        // a load touches only the addressed cell
        assign w_op = (i_op == CELL_LOAD && i_idx != IDX_W'(g)) ? CELL_HOLD : i_op;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        dq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_left  (w_left),
            .i_right (w_right),
            .i_value (i_value),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

[rtl/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit words, CAPACITY entries.
// Input channel: i_in_valid / o_in_ready carry i_op and i_push_value.
//   op 0 push front, 1 push back, 2 pop front, 3 pop back.
// Output channel: o_out_valid / i_out_ready carry o_status, o_front_value,
//   o_rear_value and o_entry_count; one result word per input word.
// Storage is two chains of cells: one packed from the front (head is the front
// entry), one packed from the rear (head is the rear entry). A push at one end
// shifts its chain by one cell and writes the other chain at the count position;
// a pop shifts the matching chain back. Every cell updates in the same cycle.
// The result is registered and valid in the cycle after the input word is accepted.
// Throughput: one word per cycle while the receiver takes results; each
//   operation is one shift or one load of each chain.
// When the receiver stalls, the result holds and o_in_ready drops until it is
//   taken; a word is accepted in the same cycle the pending result leaves.
// Reset (synchronous, active low) empties the queue and drops o_out_valid;
//   the cell contents are not cleared and never read before they are written.
// Empty queue: front and rear values read as -1. Refused pops report status 1,
//   refused pushes report status 2; neither changes the queue.
`include "double_ended_queue_macros.svh"

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [OP_W-1:0]               i_op,
    input  logic signed [VALUE_W-1:0]     i_push_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [VALUE_W-1:0]     o_front_value,
    output logic signed [VALUE_W-1:0]     o_rear_value,
    output logic [COUNT_OUT_W-1:0]        o_entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    t_status                   r_status;
    t_status                   n_status;

    t_op                       w_op;
    logic                      w_accept;
    logic                      w_is_push;
    logic                      w_full;
    logic                      w_empty;
    t_cell_op                  w_front_op;
    t_cell_op                  w_rear_op;
    logic signed [VALUE_W-1:0] w_front_head;
    logic signed [VALUE_W-1:0] w_rear_head;

    assign w_op      = t_op'(i_op);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_is_push = (w_op == OP_PUSH_FRONT) || (w_op == OP_PUSH_BACK);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);

    always_comb begin
        n_out_valid = r_out_valid;
        n_count     = r_count;
        n_status    = r_status;
        w_front_op  = CELL_HOLD;
        w_rear_op   = CELL_HOLD;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            if (w_is_push && w_full) begin
                n_status = ST_FULL;
            end else if (!w_is_push && w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                case (w_op)
                    OP_PUSH_FRONT: begin
                        w_front_op = CELL_SHR;
                        w_rear_op  = CELL_LOAD;
                        n_count    = r_count + CNT_W'(1);
                    end
                    OP_PUSH_BACK: begin
                        w_front_op = CELL_LOAD;
                        w_rear_op  = CELL_SHR;
                        n_count    = r_count + CNT_W'(1);
                    end
                    OP_POP_FRONT: begin
                        w_front_op = CELL_SHL;
                        n_count    = r_count - CNT_W'(1);
                    end
                    OP_POP_BACK: begin
                        w_rear_op = CELL_SHL;
                        n_count   = r_count - CNT_W'(1);
                    end
                    default: begin
                        n_count = r_count;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    dq_chain #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_front_chain (
        .i_clk   (i_clk),
        .i_op    (w_front_op),
        .i_idx   (r_count[IDX_W-1:0]),
        .i_value (i_push_value),
        .o_head  (w_front_head)
    );

    dq_chain #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_rear_chain (
        .i_clk   (i_clk),
        .i_op    (w_rear_op),
        .i_idx   (r_count[IDX_W-1:0]),
        .i_value (i_push_value),
        .o_head  (w_rear_head)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_front_value = w_empty ? EMPTY_VALUE : w_front_head;
    assign o_rear_value  = w_empty ? EMPTY_VALUE : w_rear_head;
    assign o_entry_count = COUNT_OUT_W'(r_count);

    `DQ_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `DQ_ASSERT(a_push_full, w_accept && w_is_push && w_full |=> r_status == ST_FULL && r_count == CNT_W'(CAPACITY), "refused push changed the queue")
    `DQ_ASSERT(a_push_grow, w_accept && w_is_push && !w_full |=> r_count == $past(r_count) + CNT_W'(1), "accepted push did not grow the count")
    `DQ_ASSERT(a_pop_empty, w_accept && !w_is_push && w_empty |=> r_status == ST_EMPTY && r_count == '0, "refused pop changed the queue")
    `DQ_ASSERT(a_stall_hold, r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_count), "stalled result lost or state moved")

endmodule

[tb/tb_double_ended_queue.sv]
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: directed table, then random bursts.
// Depends on dq_pkg and the double_ended_queue RTL; predicts every result word in-line.
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int LONG_HOLD  = 300;
    localparam int PHASE_LEN  = 170;
    localparam int NUM_PHASES = 5;
    localparam int NUM_ROWS   = 17;

    typedef struct packed {
        t_status     status;
        logic [31:0] front;
        logic [31:0] rear;
        logic [4:0]  count;
    } deque_result_t;

    typedef struct {
        t_op           op;
        logic [31:0]   value;
        int            reps;
        bit            typed;
        deque_result_t want;
    } stim_row_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [OP_W-1:0]             i_op;
    logic signed [VALUE_W-1:0]   i_push_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [STATUS_W-1:0]         o_status;
    logic signed [VALUE_W-1:0]   o_front_value;
    logic signed [VALUE_W-1:0]   o_rear_value;
    logic [COUNT_OUT_W-1:0]      o_entry_count;

    // Shadow copy of the queue
    logic [31:0]   slot_data [CAPACITY_DEF];
    logic [3:0]    head_slot;
    logic [4:0]    fill_count;

    deque_result_t pending_results [$];
    bit            row_typed;
    deque_result_t row_want;

    int n_errors;
    int n_words_in;
    int n_words_out;
    int n_full;
    int n_empty;
    int stall_pct;
    int send_idle_pct;
    int hold_req;

    stim_row_t dir_rows [NUM_ROWS];

    double_ended_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_entry_count (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic deque_result_t deque_apply(t_op op, logic [31:0] val);
        deque_result_t r;
        logic [3:0]    slot;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill_count >= CAPACITY_DEF) begin
                    r.status = ST_FULL;
                end else if (op == OP_PUSH_FRONT) begin
                    head_slot = head_slot - 4'd1;
                    slot_data[head_slot] = val;
                    fill_count = fill_count + 5'd1;
                end else begin
                    slot = head_slot + fill_count[3:0];
                    slot_data[slot] = val;
                    fill_count = fill_count + 5'd1;
                end
            end
            default: begin
                if (fill_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (op == OP_POP_FRONT) head_slot = head_slot + 4'd1;
                    fill_count = fill_count - 5'd1;
                end
            end
        endcase
        if (fill_count != 0) begin
            slot    = head_slot + fill_count[3:0] - 4'd1;
            r.front = slot_data[head_slot];
            r.rear  = slot_data[slot];
        end else begin
            r.front = EMPTY_VALUE;
            r.rear  = EMPTY_VALUE;
        end
        r.count = fill_count;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t MISMATCH %s: expected %h, got %h", $time, what, want, got);
        n_errors++;
    endtask

    // Predict on each accepted input word, check each accepted result word
    always @(posedge i_clk) begin : monitor
        deque_result_t calc;
        deque_result_t want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                calc = deque_apply(t_op'(i_op), i_push_value);
                pending_results.push_back(row_typed ? row_want : calc);
                n_words_in++;
            end
            if (o_out_valid && i_out_ready) begin
                n_words_out++;
                if (o_status == ST_FULL) n_full++;
                if (o_status == ST_EMPTY) n_empty++;
                if (pending_results.size() == 0) begin
                    flag_mismatch("result word with nothing pending", 32'd0, 32'(o_status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(o_status));
                    if (o_front_value !== want.front)
                        flag_mismatch("front value", want.front, o_front_value);
                    if (o_rear_value !== want.rear)
                        flag_mismatch("rear value", want.rear, o_rear_value);
                    if (o_entry_count !== want.count)
                        flag_mismatch("entry count", 32'(want.count), 32'(o_entry_count));
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #5ms;
        $display("tb_double_ended_queue failed");
        $finish;
    end

    task automatic send_word(t_op op, logic [31:0] val, bit typed, deque_result_t want);
        // Idle the sender at random before offering the word
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_push_value <= val;
        row_typed    <= typed;
        row_want     <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        deque_result_t no_want;
        t_op           op;
        int            mode;
        int            burst;
        int            sent;
        int            push_pct;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_PUSH_FRONT;
        i_push_value  = '0;
        i_out_ready   = 1'b0;
        row_typed     = 1'b0;
        row_want      = '0;
        no_want       = '0;
        head_slot     = '0;
        fill_count    = '0;
        n_errors      = 0;
        n_words_in    = 0;
        n_words_out   = 0;
        n_full        = 0;
        n_empty       = 0;
        stall_pct     = 0;
        send_idle_pct = 0;
        hold_req      = 0;

        dir_rows = '{
            '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{ST_EMPTY, '1, '1, 5'd0}},
            '{OP_POP_BACK,   32'h5A5A_5A5A, 1,  1'b1, '{ST_EMPTY, '1, '1, 5'd0}},
            '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1,
                '{ST_OK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1}},
            '{OP_PUSH_FRONT, 32'h8000_0000, 1,  1'b1,
                '{ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2}},
            '{OP_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1,
                '{ST_OK, 32'h8000_0000, 32'h8000_0000, 5'd1}},
            '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{ST_OK, '1, '1, 5'd0}},
            // a stored all-ones word looks like the empty marker
            '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b1, '{ST_OK, '1, '1, 5'd1}},
            '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, '{ST_OK, '1, '1, 5'd0}},
            '{OP_PUSH_BACK,  32'h0000_0001, 15, 1'b0, no_want},
            '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1,  1'b0, no_want},
            '{OP_PUSH_BACK,  32'h5555_5555, 1,  1'b1,
                '{ST_FULL, 32'hAAAA_AAAA, 32'h0000_000F, 5'd16}},
            '{OP_PUSH_FRONT, 32'h1234_5678, 1,  1'b1,
                '{ST_FULL, 32'hAAAA_AAAA, 32'h0000_000F, 5'd16}},
            '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1,
                '{ST_OK, 32'h0000_0001, 32'h0000_000F, 5'd15}},
            '{OP_POP_BACK,   32'h0000_0000, 15, 1'b0, no_want},
            '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, '{ST_EMPTY, '1, '1, 5'd0}},
            '{OP_PUSH_BACK,  32'hFFFF_0000, 1,  1'b1,
                '{ST_OK, 32'hFFFF_0000, 32'hFFFF_0000, 5'd1}},
            '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{ST_OK, '1, '1, 5'd0}}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            for (int i = 0; i < dir_rows[r].reps; i++)
                send_word(dir_rows[r].op, dir_rows[r].value + i, dir_rows[r].typed,
                          dir_rows[r].want);
        end
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1:       begin send_idle_pct = 64; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 64; end
                3:       begin send_idle_pct = 24; stall_pct = 24; end
                default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
            // Last phase: hold the receiver off while words keep coming
            if (ph == NUM_PHASES - 1) hold_req++;
            sent = 0;
            while (sent < PHASE_LEN) begin
                // Bursts lean toward filling or draining so both ends get hit
                mode  = $urandom_range(2);
                burst = $urandom_range(8, 40);
                push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
                for (int i = 0; i < burst && sent < PHASE_LEN; i++) begin
                    if ($urandom_range(99) < push_pct)
                        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                    else
                        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
                    send_word(op, pick_value(), 1'b0, no_want);
                    sent++;
                end
            end
            drain_results();
        end

        repeat (4) @(posedge i_clk);
        $display("Covered %0d words in, %0d results out, across %0d idle/stall phases.",
                 n_words_in, n_words_out, NUM_PHASES);
        $display("Refusals seen: %0d on a full queue, %0d on an empty queue.",
                 n_full, n_empty);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("tb_double_ended_queue passed");
        end else begin
            $display("tb_double_ended_queue failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/dq_chain.sv
rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
